// ===== design/mmcrc_pkg.sv =====
// Package for the multi-mode CRC-16 engine: mode codes, presets, update functions.
// No dependencies.
package mmcrc_pkg;

  localparam logic [1:0] MODE_CRC16 = 2'd0;
  localparam logic [1:0] MODE_CCITT = 2'd1;
  localparam logic [1:0] MODE_FLEX  = 2'd2;

  localparam logic [15:0] POLY_CRC16   = 16'hA001;
  localparam logic [15:0] POLY_CCITT   = 16'h8408;
  localparam logic [15:0] FLEX_PRESET  = 16'hFFFF;
  localparam logic [15:0] FLEX_XOR     = 16'h0F87;
  localparam logic [15:0] CCITT_PRESET_RST = 16'hFFFF;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_MODE   = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_PRESET = 3'd4;

  function automatic logic [15:0] reflect8(input logic [15:0] reg_in,
                                           input logic [15:0] poly);
    logic [15:0] r;
    r = reg_in;
    for (int b = 0; b < 8; b++) begin
      if (r[0]) r = (r >> 1) ^ poly;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [15:0] flex_update(input logic [15:0] crc, input logic [7:0] c);
    logic [7:0] idx;
    idx = crc[15:8] ^ c;
    return {crc[7:0], 8'h00} ^ reflect8({8'h00, idx}, POLY_CCITT) ^ FLEX_XOR;
  endfunction

endpackage

// ===== design/mmcrc_update.sv =====
// Combinational byte update of the running CRC for all three modes.
// Depends on mmcrc_pkg.
module mmcrc_update
  import mmcrc_pkg::*;
(
  input  logic [1:0]  mode,
  input  logic [15:0] preset,
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic        first,
  output logic [15:0] crc_out
);

  logic [15:0] start;

  always_comb begin
    if (!first) start = crc_in;
    else if (mode[1]) start = FLEX_PRESET;
    else if (mode == MODE_CCITT) start = preset;
    else start = 16'h0000;

    if (mode[1]) crc_out = flex_update(start, data);
    else if (mode == MODE_CCITT) crc_out = reflect8(start ^ {8'h00, data}, POLY_CCITT);
    else crc_out = reflect8(start ^ {8'h00, data}, POLY_CRC16);
  end

endmodule

// ===== design/multi_mode_crc16_engine_unit.sv =====
// Multi-mode CRC-16 engine top level: input register, CRC update, result register.
// Throughput one byte per cycle unless out_ready stalls the result register.
// Running CRC updates as each byte enters the result register; back-to-back bytes chain.
// Synchronous reset clears the running CRC to 0, mode to 0 and the CCITT preset to 0xFFFF.
// Depends on mmcrc_pkg and mmcrc_update.
module multi_mode_crc16_engine_unit
  import mmcrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       crc_value,
  output logic              frame_end,
  output logic              check_failed
);

  logic [1:0]  crc_mode;
  logic [15:0] ccitt_preset;
  logic [15:0] running_crc;
  logic        s_valid;
  logic [7:0]  s_data;
  logic        s_first, s_last;
  logic [15:0] crc_next;
  logic        s_adv;

  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      ADDR_MODE:   prdata = {30'd0, crc_mode};
      ADDR_PRESET: prdata = {16'd0, ccitt_preset};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= MODE_CRC16;
      ccitt_preset <= CCITT_PRESET_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_MODE) crc_mode <= pwdata[1:0];
      else if (paddr == ADDR_PRESET) ccitt_preset <= pwdata[15:0];
    end
  end

  mmcrc_update u_update (
    .mode(crc_mode), .preset(ccitt_preset), .crc_in(running_crc),
    .data(s_data), .first(s_first), .crc_out(crc_next)
  );

  assign s_adv = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || s_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      out_valid <= 1'b0;
      running_crc <= 16'h0000;
    end else begin
      if (in_ready) s_valid <= in_valid;
      if (s_adv) begin
        out_valid <= 1'b1;
        running_crc <= crc_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_data <= data_byte;
      s_first <= first_byte;
      s_last <= last_byte;
    end
    if (s_adv) begin
      crc_value <= crc_next;
      frame_end <= s_last;
      check_failed <= s_last && (crc_mode == MODE_CRC16) && (crc_next != 16'h0000);
    end
  end

endmodule
